[sv/ipacl_pkg.sv]
// ----------------------------------------------------------------------------
// ipacl_pkg
// Shared types, codes and helpers for the IPv4 prefix access list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ipacl_pkg;

   localparam int MAX_RULES_DEFAULT = 16;
   localparam int ADDR_W            = 32;
   localparam int LEN_W             = 6;
   localparam int HIT_W             = 4;

   typedef enum logic {
      OP_ADD   = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [ADDR_W-1:0]  addr;
      logic [LEN_W-1:0]   prefix_len;
      logic               allow;
   } req_type;

   typedef struct packed {
      logic               permit;
      logic               matched;
      logic [HIT_W-1:0]   rule_hit;
      logic               table_full;
   } rsp_type;

   // Prefix length to leading-ones mask; lengths above 32 mean exact match.
   function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
      logic [LEN_W-1:0] sat;
      logic [ADDR_W-1:0] ones;
      begin
         ones = '1;
         sat  = (len > LEN_W'(ADDR_W)) ? LEN_W'(ADDR_W) : len;
         if (sat == '0) begin
            len_mask = '0;
         end else begin
            len_mask = ones << (LEN_W'(ADDR_W) - sat);
         end
      end
   endfunction

endpackage

[sv/ipacl_match.sv]
// ----------------------------------------------------------------------------
// ipacl_match
// Parallel compare of one address against every live rule, lowest index wins.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ipacl_match #(
   parameter int MAX_RULES = ipacl_pkg::MAX_RULES_DEFAULT,
   parameter int IDX_W     = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1
) (
   input  logic [ipacl_pkg::ADDR_W-1:0]                 addr,
   input  logic [MAX_RULES-1:0][ipacl_pkg::ADDR_W-1:0]  rule_prefix,
   input  logic [MAX_RULES-1:0][ipacl_pkg::ADDR_W-1:0]  rule_mask,
   input  logic [MAX_RULES-1:0]                         rule_action,
   input  logic [MAX_RULES-1:0]                         rule_live,
   output logic                                         hit,
   output logic [IDX_W-1:0]                             hit_idx,
   output logic                                         hit_action
);
   import ipacl_pkg::*;

   logic [MAX_RULES-1:0] lane_hit;

   always_comb begin
      for (int i = 0; i < MAX_RULES; i++) begin
         lane_hit[i] = rule_live[i] && ((addr & rule_mask[i]) == rule_prefix[i]);
      end
   end

   // Priority encode: walk down so the lowest matching index is left standing.
   always_comb begin
      hit        = 1'b0;
      hit_idx    = '0;
      hit_action = 1'b0;
      for (int i = MAX_RULES - 1; i >= 0; i--) begin
         if (lane_hit[i]) begin
            hit        = 1'b1;
            hit_idx    = IDX_W'(i);
            hit_action = rule_action[i];
         end
      end
   end

endmodule

[sv/ipv4_prefix_acl_first_match_core.sv]
// ----------------------------------------------------------------------------
// ipv4_prefix_acl_first_match_core
// IPv4 access list: append rules, query addresses with first-match priority.
// ----------------------------------------------------------------------------
// One transfer is accepted per clock while req_stall is low; every transfer
// yields exactly one response, via the input register, then the result
// register. An add appends a rule at the next index, or reports table_full
// once MAX_RULES rules are held; a query compares the address against all
// stored rules at once and the lowest matching index decides, with allow as
// the default when nothing matches. An add is visible to the very next query.
// The clock path is set by the MAX_RULES-wide compare and priority encoder.
// The rule table is not cleared at reset; only the count and valid flags are.
`timescale 1ns / 1ps

module ipv4_prefix_acl_first_match_core #(
   parameter int MAX_RULES = ipacl_pkg::MAX_RULES_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  ipacl_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output ipacl_pkg::rsp_type rsp_data
);
   import ipacl_pkg::*;

   localparam int IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
   localparam int CNT_W = $clog2(MAX_RULES + 1);

   // Rule table, one lane per rule.
   logic [MAX_RULES-1:0][ADDR_W-1:0] rule_prefix_ff;
   logic [MAX_RULES-1:0][ADDR_W-1:0] rule_mask_ff;
   logic [MAX_RULES-1:0]             rule_action_ff;
   logic [CNT_W-1:0]                 rule_count_ff, rule_count_in;
   logic [MAX_RULES-1:0]             rule_live;

   logic    s1_valid_ff, s1_valid_in;
   req_type s1_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;

   logic             out_open, s1_adv, req_take;
   logic             table_is_full, do_write;
   logic             hit, hit_action;
   logic [IDX_W-1:0] hit_idx;
   logic [IDX_W+HIT_W-1:0] hit_wide;
   logic [CNT_W+HIT_W-1:0] cnt_wide;

   assign out_open  = !out_valid_ff || !rsp_stall;
   assign s1_adv    = s1_valid_ff && out_open;
   assign req_stall = s1_valid_ff && !out_open;
   assign req_take  = req_valid && !req_stall;

   assign s1_valid_in  = req_take || (s1_valid_ff && !s1_adv);
   assign out_valid_in = s1_adv || (out_valid_ff && rsp_stall);

   assign table_is_full = (rule_count_ff == CNT_W'(MAX_RULES));
   assign do_write      = s1_adv && (s1_data_ff.op == OP_ADD) && !table_is_full;
   assign rule_count_in = do_write ? rule_count_ff + CNT_W'(1) : rule_count_ff;

   always_comb begin
      for (int i = 0; i < MAX_RULES; i++) begin
         rule_live[i] = (CNT_W'(i) < rule_count_ff);
      end
   end

   ipacl_match #(
      .MAX_RULES (MAX_RULES),
      .IDX_W     (IDX_W)
   ) u_match (
      .addr        (s1_data_ff.addr),
      .rule_prefix (rule_prefix_ff),
      .rule_mask   (rule_mask_ff),
      .rule_action (rule_action_ff),
      .rule_live   (rule_live),
      .hit         (hit),
      .hit_idx     (hit_idx),
      .hit_action  (hit_action)
   );

   // Index reported is the low bits, zero-extended when the table is small.
   assign hit_wide = {{HIT_W{1'b0}}, hit_idx};
   assign cnt_wide = {{HIT_W{1'b0}}, rule_count_ff};

   always_comb begin
      out_data_in = '0;
      if (s1_data_ff.op == OP_QUERY) begin
         out_data_in.permit  = hit ? hit_action : 1'b1;
         out_data_in.matched = hit;
         if (hit) begin
            out_data_in.rule_hit = hit_wide[HIT_W-1:0];
         end
      end else if (table_is_full) begin
         out_data_in.table_full = 1'b1;
      end else begin
         out_data_in.rule_hit = cnt_wide[HIT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         rule_count_ff <= '0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         out_valid_ff  <= out_valid_in;
         rule_count_ff <= rule_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_data_ff <= req_data;
      end
      if (s1_adv) begin
         out_data_ff <= out_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         rule_mask_ff[rule_count_ff[IDX_W-1:0]]   <= len_mask(s1_data_ff.prefix_len);
         rule_prefix_ff[rule_count_ff[IDX_W-1:0]] <=
            s1_data_ff.addr & len_mask(s1_data_ff.prefix_len);
         rule_action_ff[rule_count_ff[IDX_W-1:0]] <= s1_data_ff.allow;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

`ifndef SYNTHESIS
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      rule_count_ff <= CNT_W'(MAX_RULES))
      else $error("rule count beyond table depth");

   a_full_flag : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.table_full |-> table_is_full)
      else $error("table_full reported while table has room");

   a_match_needs_rule : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.matched |-> rule_count_ff != '0)
      else $error("match reported with empty table");
`endif

endmodule

[bench/acl_checker.sv]
// ----------------------------------------------------------------------------
// acl_checker
// Watches both channels of the access list, keeps its own rule table and
// checks every response against the verdict it predicts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module acl_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  ipacl_pkg::req_type req_data,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  ipacl_pkg::rsp_type rsp_data,
   output int                 fail_count,
   output int                 pending,
   output int                 add_count,
   output int                 drop_count,
   output int                 hit_count,
   output int                 default_count
);
   import ipacl_pkg::*;

   localparam int RULE_SLOTS = MAX_RULES_DEFAULT;

   logic [ADDR_W-1:0] acl_prefix [RULE_SLOTS];
   logic [LEN_W-1:0]  acl_len    [RULE_SLOTS];
   logic              acl_action [RULE_SLOTS];
   int                acl_used;
   rsp_type           verdict_q [$];

   // Leading-ones mask; any length of 32 or more covers the whole address.
   function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
      logic [ADDR_W-1:0] m;
      m = '0;
      for (int b = 0; b < ADDR_W; b++) begin
         if (b < len) m[ADDR_W-1-b] = 1'b1;
      end
      return m;
   endfunction

   task automatic report_mismatch(input string what, input int want, input int got);
      $display("%0t ns mismatch: %s expected %0d got %0d", $time, what, want, got);
      fail_count++;
   endtask

   task automatic judge_request(input req_type rq);
      rsp_type           v;
      logic [ADDR_W-1:0] m;
      v = '0;
      if (rq.op == OP_ADD) begin
         add_count++;
         if (acl_used >= RULE_SLOTS) begin
            v.table_full = 1'b1;
            drop_count++;
         end else begin
            m = prefix_mask(rq.prefix_len);
            acl_prefix[acl_used] = rq.addr & m;
            acl_len[acl_used]    = rq.prefix_len;
            acl_action[acl_used] = rq.allow;
            v.rule_hit           = HIT_W'(acl_used);
            acl_used++;
         end
      end else begin
         v.permit = 1'b1;
         // lowest index wins: stop at the first hit
         for (int i = 0; i < acl_used && !v.matched; i++) begin
            m = prefix_mask(acl_len[i]);
            if (((rq.addr ^ acl_prefix[i]) & m) == '0) begin
               v.permit   = acl_action[i];
               v.matched  = 1'b1;
               v.rule_hit = HIT_W'(i);
            end
         end
         if (v.matched) hit_count++;
         else default_count++;
      end
      verdict_q = {verdict_q, v};
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         acl_used = 0;
         verdict_q.delete();
         fail_count    = 0;
         add_count     = 0;
         drop_count    = 0;
         hit_count     = 0;
         default_count = 0;
      end else begin
         if (req_valid && !req_stall) judge_request(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (verdict_q.size() == 0) begin
               report_mismatch("response transfer with nothing outstanding", 0, 1);
            end else begin
               want = verdict_q.pop_front();
               if (rsp_data.permit !== want.permit)
                  report_mismatch("permit", want.permit, rsp_data.permit);
               if (rsp_data.matched !== want.matched)
                  report_mismatch("matched", want.matched, rsp_data.matched);
               if (rsp_data.rule_hit !== want.rule_hit)
                  report_mismatch("rule_hit", want.rule_hit, rsp_data.rule_hit);
               if (rsp_data.table_full !== want.table_full)
                  report_mismatch("table_full", want.table_full, rsp_data.table_full);
            end
         end
      end
      pending = verdict_q.size();
   end

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives rule adds and address queries into the IPv4 access list with random
// gaps and back-pressure; the checker beside the block judges every response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import ipacl_pkg::*;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int fail_count, pending, add_count, drop_count, hit_count, default_count;

   // no idling on either side while set
   logic calm = 1'b0;

   // rules handed to the block so far, used only to aim queries at them
   logic [ADDR_W-1:0] stim_prefix [MAX_RULES_DEFAULT];
   int                stim_len    [MAX_RULES_DEFAULT];
   int                rules_sent = 0;

   int                n, pick, r, l;
   logic [ADDR_W-1:0] a, m;

   always #2 clock = ~clock;

   ipv4_prefix_acl_first_match_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   acl_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending       (pending),
      .add_count     (add_count),
      .drop_count    (drop_count),
      .hit_count     (hit_count),
      .default_count (default_count)
   );

   always @(negedge clock) begin
      rsp_stall <= (reset || calm) ? 1'b0 : ($urandom_range(99) < 22);
   end

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_req(input req_type item);
      if (!calm && $urandom_range(99) < 22) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic send_add(input logic [ADDR_W-1:0] addr, input logic [LEN_W-1:0] len,
                           input logic act);
      req_type rq;
      rq.op         = OP_ADD;
      rq.addr       = addr;
      rq.prefix_len = len;
      rq.allow      = act;
      if (rules_sent < MAX_RULES_DEFAULT) begin
         stim_prefix[rules_sent] = addr;
         stim_len[rules_sent]    = (len > ADDR_W) ? ADDR_W : len;
      end
      rules_sent++;
      send_req(rq);
   endtask

   // prefix_len and allow carry random junk on a query
   task automatic send_query(input logic [ADDR_W-1:0] addr);
      req_type rq;
      rq.op         = OP_QUERY;
      rq.addr       = addr;
      rq.prefix_len = LEN_W'($urandom_range(0, 63));
      rq.allow      = 1'($urandom_range(0, 1));
      send_req(rq);
   endtask

   initial begin
      #2000000;
      $display("status: fail");
      $finish;
   end

   initial begin
      req_valid = 1'b0;
      req_data  = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty table: default allow
      send_query(32'h0000_0000);
      send_query(32'hFFFF_FFFF);
      // full-length deny, exact match only
      send_add(32'hFFFF_FFFF, 6'd32, 1'b0);
      send_query(32'hFFFF_FFFF);
      send_query(32'hFFFF_FFFE);
      // junk below the prefix, then a duplicate prefix with the other action
      send_add(32'h0A12_3456, 6'd8, 1'b0);
      send_add(32'h0A00_0000, 6'd8, 1'b1);
      send_query(32'h0AFF_FFFF);
      // oversize length saturates to an exact match
      send_add(32'h0000_0000, 6'd63, 1'b1);
      send_query(32'h0000_0000);
      send_query(32'h0000_0001);
      // wider rule shadows a narrower one added later
      send_add(32'hC0A8_0000, 6'd16, 1'b1);
      send_add(32'hC0A8_0100, 6'd24, 1'b0);
      send_query(32'hC0A8_0105);
      send_add(32'h8000_0000, 6'd1, 1'b0);
      send_query(32'h8000_0001);
      send_add(32'h1234_5678, 6'd33, 1'b1);
      send_query(32'h1234_5678);
      send_query(32'h1234_5679);
      send_query(32'h7FFF_FFFF);

      for (n = 0; n < 1900; n++) begin
         calm = (n >= 1300 && n < 1600);
         if (n == 1000) begin
            // hold off until the pipeline has drained
            req_valid <= 1'b0;
            do @(negedge clock); while (pending != 0);
         end
         pick = $urandom_range(99);
         if (rules_sent < MAX_RULES_DEFAULT && pick < 2) begin
            // the last slot gets a catch-all rule so it cannot shadow the others
            if (rules_sent == MAX_RULES_DEFAULT - 1) l = 0;
            else if ($urandom_range(99) < 15) l = $urandom_range(33, 63);
            else l = $urandom_range(1, 32);
            send_add($urandom, LEN_W'(l), 1'($urandom_range(0, 1)));
         end else if (rules_sent >= MAX_RULES_DEFAULT && pick < 10) begin
            send_add($urandom, LEN_W'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
         end else begin
            pick = $urandom_range(99);
            if (rules_sent == 0 || pick < 30) begin
               a = $urandom;
            end else begin
               r = $urandom_range(0, ((rules_sent < MAX_RULES_DEFAULT) ?
                                      rules_sent : MAX_RULES_DEFAULT) - 1);
               l = stim_len[r];
               m = (l == 0) ? '0 : ('1 << (ADDR_W - l));
               a = (stim_prefix[r] & m) | ($urandom & ~m);
               // near miss: flip the last bit inside the prefix
               if (pick < 45 && l > 0) a = a ^ (32'h1 << (ADDR_W - l));
            end
            send_query(a);
         end
      end
      req_valid <= 1'b0;
      calm = 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("covered %0d adds (%0d dropped on a full table) and %0d queries",
               add_count, drop_count, hit_count + default_count);
      $display("queries: %0d decided by a rule, %0d by the default allow",
               hit_count, default_count);
      if (fail_count == 0 && pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

[sim.f]
sv/ipacl_pkg.sv
sv/ipacl_match.sv
sv/ipv4_prefix_acl_first_match_core.sv
bench/acl_checker.sv
bench/testbench.sv
